>>> rtl/stadsr_pkg.sv
package stadsr_pkg;

  localparam int PHASE_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
  localparam int SINE_QBITS       = SINE_ADDR_BITS - 2;

  localparam int STEP_BITS     = 23;
  localparam int INDEX_BITS    = 14;
  localparam int LEN_BITS      = 12;
  localparam int LEVEL_BITS    = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int SINE_MAG_BITS = 15;
  localparam int MP_BITS       = LEVEL_BITS + LEN_BITS;
  localparam int SV_BITS       = SINE_MAG_BITS + LEVEL_BITS;
  localparam int PROD_BITS     = SV_BITS + LEVEL_BITS;
  localparam int PROD_SHIFT    = 29;
  localparam int MAG_BITS      = PROD_BITS - PROD_SHIFT;
  localparam int CNT_BITS      = $clog2(LEVEL_BITS);

  localparam logic [INDEX_BITS-1:0] INDEX_MAX    = '1;
  localparam logic [MAG_BITS-1:0]   SAMPLE_POS   = MAG_BITS'(32767);
  localparam logic [MAG_BITS-1:0]   SAMPLE_NEG   = MAG_BITS'(32768);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP  = 16'h7FFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_BOT  = 16'h8000;

  localparam int NUM_REGS   = 7;
  localparam int PADDR_BITS = $clog2(NUM_REGS * 4);
  localparam int PDATA_BITS = 32;
  localparam int REG_BITS   = PADDR_BITS - 2;

  localparam logic [LEN_BITS-1:0]   ATTACK_RESET  = 12'd128;
  localparam logic [LEN_BITS-1:0]   DECAY_RESET   = 12'd128;
  localparam logic [LEN_BITS-1:0]   SUSTAIN_RESET = 12'd1408;
  localparam logic [LEN_BITS-1:0]   RELEASE_RESET = 12'd384;
  localparam logic [LEVEL_BITS-1:0] PEAK_RESET    = 16'd32768;
  localparam logic [LEVEL_BITS-1:0] HOLD_RESET    = 16'd16384;
  localparam logic [LEVEL_BITS-1:0] VOLUME_RESET  = 16'h0100;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] SINE_FULL   = 64'd32767;

  typedef struct packed {
    logic                 restart;
    logic [STEP_BITS-1:0] phase_inc;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          envelope_done;
  } out_item_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]   attack_length;
    logic [LEN_BITS-1:0]   decay_length;
    logic [LEN_BITS-1:0]   sustain_length;
    logic [LEN_BITS-1:0]   release_length;
    logic [LEVEL_BITS-1:0] peak_level;
    logic [LEVEL_BITS-1:0] hold_level;
    logic [LEVEL_BITS-1:0] volume;
  } cfg_t;

  typedef struct packed {
    logic                  ready;
    logic                  done;
    logic [LEVEL_BITS-1:0] level;
  } env_stat_t;

  typedef enum logic [REG_BITS-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_PEAK    = 3'd4,
    REG_HOLD    = 3'd5,
    REG_VOLUME  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEG_ATTACK,
    SEG_DECAY,
    SEG_SUSTAIN,
    SEG_RELEASE
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_START_ENV,
    ST_WAIT_ENV,
    ST_START_OUT,
    ST_WAIT_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_WALK,
    E_MUL,
    E_DIV,
    E_FIN
  } env_state_t;

  typedef enum logic {
    M_IDLE,
    M_RUN
  } mul_state_t;

  function automatic logic [SINE_MAG_BITS-1:0] sine_quarter(input logic [63:0] m);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] val;
    r    = m << (30 - SINE_QBITS);
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    sum  = x;
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    val  = (sum * SINE_FULL + (ONE_Q30 >> 1)) >> 30;
    if (val > SINE_FULL) begin
      val = SINE_FULL;
    end
    return val[SINE_MAG_BITS-1:0];
  endfunction

  typedef logic [SINE_MAG_BITS-1:0] sine_rom_t [SINE_QUARTER];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int m = 0; m < SINE_QUARTER; m++) begin
      rom[m] = sine_quarter(64'(m));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic [SINE_MAG_BITS-1:0] SINE_PEAK = sine_quarter(64'(SINE_QUARTER));

endpackage

>>> rtl/sine_tone_with_adsr_envelope.sv
// A request goes through the sine lookup, then the envelope unit (a 12-step shift-add
// and a 16-step restoring divide, longest while the envelope ramps in release) and the
// 16-step serial multiplier, which applies the volume and then the envelope.
// One request is taken at a time; the output register frees the input side.
// Reset (rst, synchronous): phase and sample index to zero, registers to their defaults.
module sine_tone_with_adsr_envelope (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  stadsr_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output stadsr_pkg::out_item_t               out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stadsr_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [stadsr_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [stadsr_pkg::PDATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import stadsr_pkg::*;

  top_state_t              state;
  top_state_t              state_next;
  cfg_t                    cfg;
  logic [PHASE_BITS-1:0]   phase;
  logic [INDEX_BITS-1:0]   index;
  logic [SINE_ADDR_BITS-1:0] rom_k;
  logic [INDEX_BITS-1:0]   idx_work;
  logic [SINE_MAG_BITS-1:0] sine_mag;
  logic                    sine_neg;

  logic                    in_accept;
  logic                    cfg_write;
  logic [REG_BITS-1:0]     reg_sel;
  logic [PHASE_BITS-1:0]   phase_base;
  logic [PHASE_BITS-1:0]   phase_next;
  logic [INDEX_BITS-1:0]   index_base;
  logic [INDEX_BITS-1:0]   index_next;
  logic [SINE_QBITS-1:0]   rom_j;
  logic [SINE_QBITS-1:0]   rom_jm;
  logic [SINE_MAG_BITS-1:0] sine_lookup;

  logic                    env_start;
  logic                    mul_start;
  logic [SV_BITS-1:0]      mul_a;
  logic [LEVEL_BITS-1:0]   mul_b;
  logic                    out_load;
  env_stat_t               env_stat;
  logic                    mul_ready;
  logic [PROD_BITS-1:0]    product;
  logic [MAG_BITS-1:0]     mag;
  logic [MAG_BITS-1:0]     mag_neg;
  logic [SAMPLE_BITS-1:0]  sample;

  stadsr_env u_env (
    .clk   (clk),
    .rst   (rst),
    .start (env_start),
    .index (idx_work),
    .cfg   (cfg),
    .stat  (env_stat)
  );

  stadsr_smul u_smul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .ready   (mul_ready),
    .product (product)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[PADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_length  <= ATTACK_RESET;
      cfg.decay_length   <= DECAY_RESET;
      cfg.sustain_length <= SUSTAIN_RESET;
      cfg.release_length <= RELEASE_RESET;
      cfg.peak_level     <= PEAK_RESET;
      cfg.hold_level     <= HOLD_RESET;
      cfg.volume         <= VOLUME_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_ATTACK:  cfg.attack_length  <= pwdata[LEN_BITS-1:0];
        REG_DECAY:   cfg.decay_length   <= pwdata[LEN_BITS-1:0];
        REG_SUSTAIN: cfg.sustain_length <= pwdata[LEN_BITS-1:0];
        REG_RELEASE: cfg.release_length <= pwdata[LEN_BITS-1:0];
        REG_PEAK:    cfg.peak_level     <= pwdata[LEVEL_BITS-1:0];
        REG_HOLD:    cfg.hold_level     <= pwdata[LEVEL_BITS-1:0];
        REG_VOLUME:  cfg.volume         <= pwdata[LEVEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ATTACK:  prdata = PDATA_BITS'(cfg.attack_length);
      REG_DECAY:   prdata = PDATA_BITS'(cfg.decay_length);
      REG_SUSTAIN: prdata = PDATA_BITS'(cfg.sustain_length);
      REG_RELEASE: prdata = PDATA_BITS'(cfg.release_length);
      REG_PEAK:    prdata = PDATA_BITS'(cfg.peak_level);
      REG_HOLD:    prdata = PDATA_BITS'(cfg.hold_level);
      REG_VOLUME:  prdata = PDATA_BITS'(cfg.volume);
      default:     prdata = '0;
    endcase
  end

  assign in_accept  = in_valid && in_ready;
  assign phase_base = in_data.restart ? '0 : phase;
  assign index_base = in_data.restart ? '0 : index;
  assign phase_next = phase_base + PHASE_BITS'(in_data.phase_inc);
  assign index_next = (index_base < INDEX_MAX) ? index_base + 1'b1 : index_base;

  assign rom_j  = rom_k[SINE_QBITS-1:0];
  assign rom_jm = SINE_QBITS'(0) - rom_j;

  always_comb begin
    if (!rom_k[SINE_QBITS]) begin
      sine_lookup = SINE_ROM[rom_j];
    end else if (rom_j == '0) begin
      sine_lookup = SINE_PEAK;
    end else begin
      sine_lookup = SINE_ROM[rom_jm];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK:      state_next = ST_START_ENV;
      ST_START_ENV: state_next = ST_WAIT_ENV;
      ST_WAIT_ENV: begin
        if (env_stat.ready && mul_ready) begin
          state_next = ST_START_OUT;
        end
      end
      ST_START_OUT: state_next = ST_WAIT_OUT;
      ST_WAIT_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    env_start = (state == ST_START_ENV);
    mul_start = (state == ST_START_ENV) || (state == ST_START_OUT);
    mul_a     = (state == ST_START_ENV) ? SV_BITS'(sine_mag) : product[SV_BITS-1:0];
    mul_b     = (state == ST_START_ENV) ? cfg.volume : env_stat.level;
    out_load  = (state == ST_WAIT_OUT) && mul_ready && (!out_valid || out_ready);
  end

  assign mag     = product[PROD_BITS-1:PROD_SHIFT];
  assign mag_neg = MAG_BITS'(0) - mag;

  always_comb begin
    if (sine_neg) begin
      sample = (mag > SAMPLE_NEG) ? SAMPLE_BOT : mag_neg[SAMPLE_BITS-1:0];
    end else begin
      sample = (mag > SAMPLE_POS) ? SAMPLE_TOP : mag[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      index     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        phase <= phase_next;
        index <= index_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rom_k    <= phase_base[PHASE_BITS-1 -: SINE_ADDR_BITS];
      idx_work <= index_base;
    end
    if (state == ST_LOOK) begin
      sine_mag <= sine_lookup;
      sine_neg <= rom_k[SINE_ADDR_BITS-1];
    end
    if (out_load) begin
      out_data.left_sample   <= sample;
      out_data.right_sample  <= sample;
      out_data.envelope_done <= env_stat.done;
    end
  end

endmodule

>>> rtl/stadsr_env.sv
module stadsr_env (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [stadsr_pkg::INDEX_BITS-1:0] index,
  input  stadsr_pkg::cfg_t                cfg,
  output stadsr_pkg::env_stat_t           stat
);
  import stadsr_pkg::*;

  env_state_t            state;
  env_state_t            state_next;
  seg_t                  walk;
  logic [CNT_BITS-1:0]   cnt;
  logic [INDEX_BITS-1:0] rel;
  logic [MP_BITS-1:0]    mp;
  logic [LEVEL_BITS-1:0] mult;
  logic [LEVEL_BITS-1:0] base;
  logic [LEVEL_BITS-1:0] level;
  logic [LEN_BITS-1:0]   den;
  logic                  sub;
  logic                  done_flag;

  logic [LEN_BITS-1:0]   len;
  logic                  hit;
  logic [LEVEL_BITS:0]   diff;
  logic [LEVEL_BITS-1:0] diff_mag;
  logic [LEVEL_BITS:0]   msum;
  logic [LEN_BITS:0]     trial;
  logic [LEN_BITS:0]     trial_sub;
  logic                  take;

  always_comb begin
    case (walk)
      SEG_ATTACK:  len = cfg.attack_length;
      SEG_DECAY:   len = cfg.decay_length;
      SEG_SUSTAIN: len = cfg.sustain_length;
      default:     len = cfg.release_length;
    endcase
  end

  assign hit       = rel < INDEX_BITS'(len);
  assign diff      = {1'b0, cfg.peak_level} - {1'b0, cfg.hold_level};
  assign diff_mag  = diff[LEVEL_BITS] ? (LEVEL_BITS'(0) - diff[LEVEL_BITS-1:0])
                                      : diff[LEVEL_BITS-1:0];
  assign msum      = {1'b0, mp[MP_BITS-1:LEN_BITS]} + (mp[0] ? {1'b0, mult} : '0);
  assign trial     = {mp[MP_BITS-1:LEVEL_BITS], mp[LEVEL_BITS-1]};
  assign take      = trial >= {1'b0, den};
  assign trial_sub = take ? (trial - {1'b0, den}) : trial;

  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE: begin
        if (start) begin
          state_next = E_WALK;
        end
      end
      E_WALK: begin
        if (hit) begin
          state_next = (walk == SEG_SUSTAIN) ? E_FIN : E_MUL;
        end else if (walk == SEG_RELEASE) begin
          state_next = E_FIN;
        end
      end
      E_MUL: begin
        if (cnt == CNT_BITS'(LEN_BITS - 1)) begin
          state_next = E_DIV;
        end
      end
      E_DIV: begin
        if (cnt == CNT_BITS'(LEVEL_BITS - 1)) begin
          state_next = E_FIN;
        end
      end
      E_FIN: begin
        state_next = E_IDLE;
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_comb begin
    stat.ready = (state == E_IDLE);
    stat.done  = done_flag;
    stat.level = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        if (start) begin
          rel       <= index;
          walk      <= SEG_ATTACK;
          done_flag <= 1'b0;
        end
      end
      E_WALK: begin
        walk      <= seg_t'(walk + 2'd1);
        cnt       <= '0;
        done_flag <= (walk == SEG_RELEASE) && !hit;
        if (!hit) begin
          rel  <= rel - INDEX_BITS'(len);
          mp   <= '0;
          base <= '0;
          sub  <= 1'b0;
        end else begin
          case (walk)
            SEG_ATTACK: begin
              mult <= cfg.peak_level;
              den  <= cfg.attack_length;
              mp   <= MP_BITS'(rel[LEN_BITS-1:0]);
              base <= '0;
              sub  <= 1'b0;
            end
            SEG_DECAY: begin
              mult <= diff_mag;
              den  <= cfg.decay_length;
              mp   <= MP_BITS'(cfg.decay_length - rel[LEN_BITS-1:0]);
              base <= cfg.hold_level;
              sub  <= diff[LEVEL_BITS];
            end
            SEG_SUSTAIN: begin
              mp   <= '0;
              base <= cfg.hold_level;
              sub  <= 1'b0;
            end
            default: begin
              mult <= cfg.hold_level;
              den  <= cfg.release_length;
              mp   <= MP_BITS'(cfg.release_length - rel[LEN_BITS-1:0]);
              base <= '0;
              sub  <= 1'b0;
            end
          endcase
        end
      end
      E_MUL: begin
        mp  <= {msum, mp[LEN_BITS-1:1]};
        cnt <= (cnt == CNT_BITS'(LEN_BITS - 1)) ? '0 : cnt + 1'b1;
      end
      E_DIV: begin
        mp  <= {trial_sub[LEN_BITS-1:0], mp[LEVEL_BITS-2:0], take};
        cnt <= cnt + 1'b1;
      end
      E_FIN: begin
        level <= sub ? (base - mp[LEVEL_BITS-1:0]) : (base + mp[LEVEL_BITS-1:0]);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/stadsr_smul.sv
module stadsr_smul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [stadsr_pkg::SV_BITS-1:0]    a,
  input  logic [stadsr_pkg::LEVEL_BITS-1:0] b,
  output logic                              ready,
  output logic [stadsr_pkg::PROD_BITS-1:0]  product
);
  import stadsr_pkg::*;

  mul_state_t          state;
  mul_state_t          state_next;
  logic [CNT_BITS-1:0] cnt;
  logic [SV_BITS-1:0]  a_reg;
  logic [PROD_BITS-1:0] p;
  logic [SV_BITS:0]    psum;

  assign psum = {1'b0, p[PROD_BITS-1:LEVEL_BITS]} + (p[0] ? {1'b0, a_reg} : '0);

  always_comb begin
    state_next = state;
    unique case (state)
      M_IDLE: begin
        if (start) begin
          state_next = M_RUN;
        end
      end
      M_RUN: begin
        if (cnt == CNT_BITS'(LEVEL_BITS - 1)) begin
          state_next = M_IDLE;
        end
      end
      default: state_next = M_IDLE;
    endcase
  end

  always_comb begin
    ready   = (state == M_IDLE);
    product = p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == M_IDLE) begin
      if (start) begin
        a_reg <= a;
        p     <= PROD_BITS'(b);
        cnt   <= '0;
      end
    end else begin
      p   <= {psum, p[LEVEL_BITS-1:1]};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

>>> rtl/stadsr_check.sv
module stadsr_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input stadsr_pkg::in_item_t              in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input stadsr_pkg::out_item_t             out_data
);
  import stadsr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_stereo_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.left_sample == out_data.right_sample)
    else $error("left and right samples differ");

endmodule

bind sine_tone_with_adsr_envelope stadsr_check u_stadsr_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stadsr_pkg::*;

  localparam logic [REG_BITS-1:0] REG_SPARE = 3'd7;
  localparam logic [63:0] Q30_UNIT = 64'd1 << 30;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int LONG_RUN = 32;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_TICKS = 55;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;

  in_item_t pending_ticks[$];
  out_item_t expected_samples[$];
  cfg_t shadow;
  logic [PHASE_BITS-1:0] ph_acc;
  logic [INDEX_BITS-1:0] smp_idx;
  bit calm = 1'b0;
  logic hold_start = 1'b0;
  int hold_left = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int err_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int settings_cnt = 0;
  out_item_t want;

  sine_tone_with_adsr_envelope i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint sine_value(input logic [63:0] k);
    logic [63:0] turn, r, x, x2, term, sum, v;
    logic [1:0] quad;
    turn = (k << 32) / SINE_TABLE_DEPTH;
    quad = turn[31:30];
    r = turn & (Q30_UNIT - 64'd1);
    if (quad[0]) begin
      r = Q30_UNIT - r;
    end
    x = (r * QUARTER_TURN_Q30) >> 30;
    x2 = (x * x) >> 30;
    sum = x;
    term = ((x * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    v = (sum * 64'd32767 + (Q30_UNIT >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint adsr_level(input longint i);
    longint a, d, s, r, p, h, left_n;
    a = shadow.attack_length;
    d = shadow.decay_length;
    s = shadow.sustain_length;
    r = shadow.release_length;
    p = shadow.peak_level;
    h = shadow.hold_level;
    if (i < a) return p * i / a;
    if (i < a + d) return h + (p - h) * (d - (i - a)) / d;
    if (i < a + d + s) return h;
    left_n = r - (i - (a + d + s));
    if (left_n <= 0) return 0;
    return h * left_n / r;
  endfunction

  function automatic out_item_t synth_sample(input in_item_t req);
    logic [63:0] addr;
    longint sv, env, vol, prod, mag, res, env_end;
    out_item_t o;
    if (req.restart) begin
      ph_acc = '0;
      smp_idx = '0;
    end
    addr = (64'(ph_acc) * SINE_TABLE_DEPTH) >> PHASE_BITS;
    sv = sine_value(addr);
    env = adsr_level(longint'(smp_idx));
    vol = shadow.volume;
    prod = sv * env * vol;
    mag = ((prod < 0) ? -prod : prod) >> 29;
    res = (prod < 0) ? -mag : mag;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    env_end = longint'(shadow.attack_length) + longint'(shadow.decay_length)
            + longint'(shadow.sustain_length) + longint'(shadow.release_length);
    o.left_sample = res[15:0];
    o.right_sample = res[15:0];
    o.envelope_done = (longint'(smp_idx) >= env_end);
    ph_acc = ph_acc + PHASE_BITS'(req.phase_inc);
    if (smp_idx != INDEX_MAX) begin
      smp_idx = smp_idx + 1'b1;
    end
    return o;
  endfunction

  task automatic flag_mismatch(input string what);
    err_cnt++;
    $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
      ph_acc = '0;
      smp_idx = '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_samples.push_back(synth_sample(in_data));
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_ticks.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          tx_gap <= $urandom_range(0, 4);
        end else if (pending_ticks.size() != 0) begin
          in_data <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        checked_cnt++;
        if (expected_samples.size() == 0) begin
          flag_mismatch("sample delivered with no request pending");
        end else begin
          want = expected_samples.pop_front();
          if (out_data.left_sample !== want.left_sample) begin
            flag_mismatch($sformatf("left_sample %0d, predicted %0d",
                                    out_data.left_sample, want.left_sample));
          end
          if (out_data.right_sample !== want.right_sample) begin
            flag_mismatch($sformatf("right_sample %0d, predicted %0d",
                                    out_data.right_sample, want.right_sample));
          end
          if (out_data.envelope_done !== want.envelope_done) begin
            flag_mismatch($sformatf("envelope_done %b, predicted %b",
                                    out_data.envelope_done, want.envelope_done));
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        out_ready <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        rx_gap <= $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [REG_BITS-1:0] idx, input logic [PDATA_BITS-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ATTACK:  shadow.attack_length = val[LEN_BITS-1:0];
      REG_DECAY:   shadow.decay_length = val[LEN_BITS-1:0];
      REG_SUSTAIN: shadow.sustain_length = val[LEN_BITS-1:0];
      REG_RELEASE: shadow.release_length = val[LEN_BITS-1:0];
      REG_PEAK:    shadow.peak_level = val[LEVEL_BITS-1:0];
      REG_HOLD:    shadow.hold_level = val[LEVEL_BITS-1:0];
      REG_VOLUME:  shadow.volume = val[LEVEL_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [LEN_BITS-1:0] a, input logic [LEN_BITS-1:0] d,
                                input logic [LEN_BITS-1:0] s, input logic [LEN_BITS-1:0] r,
                                input logic [LEVEL_BITS-1:0] p,
                                input logic [LEVEL_BITS-1:0] h,
                                input logic [LEVEL_BITS-1:0] v);
    write_reg(REG_ATTACK, {20'($urandom), a});
    write_reg(REG_DECAY, {20'($urandom), d});
    write_reg(REG_SUSTAIN, {20'($urandom), s});
    write_reg(REG_RELEASE, {20'($urandom), r});
    write_reg(REG_PEAK, {16'($urandom), p});
    write_reg(REG_HOLD, {16'($urandom), h});
    write_reg(REG_VOLUME, {16'($urandom), v});
    settings_cnt++;
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || in_valid || expected_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_tick(input logic restart, input logic [STEP_BITS-1:0] step);
    in_item_t req;
    req.restart = restart;
    req.phase_inc = step;
    pending_ticks.push_back(req);
  endtask

  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return STEP_BITS'($urandom_range(1, 64));
      default: return STEP_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_BITS-1:0] pick_length();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return LEN_BITS'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [LEVEL_BITS-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return LEVEL_BITS'($urandom);
    endcase
  endfunction

  task automatic add_notes(input int count);
    int left_n, note_len;
    left_n = count;
    while (left_n > 0) begin
      note_len = $urandom_range(15, 60);
      if (note_len > left_n) note_len = left_n;
      for (int n = 0; n < note_len; n++) begin
        add_tick((n == 0) || ($urandom_range(0, 24) == 0), pick_step());
      end
      left_n -= note_len;
    end
  endtask

  initial begin
    shadow.attack_length = ATTACK_RESET;
    shadow.decay_length = DECAY_RESET;
    shadow.sustain_length = SUSTAIN_RESET;
    shadow.release_length = RELEASE_RESET;
    shadow.peak_level = PEAK_RESET;
    shadow.hold_level = HOLD_RESET;
    shadow.volume = VOLUME_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_tick(1'b1, '0);
    add_tick(1'b0, '1);
    add_tick(1'b0, 23'h2AAAAA);
    add_tick(1'b0, 23'h155555);
    add_tick(1'b0, 23'd1);
    add_tick(1'b1, '1);
    settle();

    apply_settings(12'd3, 12'd2, 12'd2, 12'd3, 16'hFFFF, 16'd40000, 16'hFFFF);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    add_tick(1'b1, '1);
    add_tick(1'b0, '0);
    add_tick(1'b0, 23'd1);
    add_tick(1'b0, '1);
    add_tick(1'b0, '1);
    add_tick(1'b0, '1);
    add_tick(1'b0, 23'h400000);
    add_tick(1'b0, 23'h0A5A5A);
    add_tick(1'b0, 23'h75A5A5);
    add_tick(1'b0, 23'h123456);
    add_tick(1'b0, 23'h654321);
    add_tick(1'b0, 23'h3FFFFF);
    add_tick(1'b1, '0);
    add_tick(1'b0, 23'h000800);
    settle();

    apply_settings('0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_tick(1'b1, 23'h100000);
    add_tick(1'b0, 23'h100000);
    add_tick(1'b0, 23'h100000);
    settle();

    apply_settings('0, '0, 12'd2, '0, '0, 16'd30000, 16'd5000);
    add_tick(1'b1, 23'h080000);
    add_tick(1'b0, 23'h080000);
    add_tick(1'b0, 23'h080000);
    settle();

    // one long note: walk every segment and run on past the end of release
    calm = 1'b1;
    apply_settings(12'd7, 12'd5, 12'd6, 12'd8, 16'hFFFF, 16'd20000, 16'd300);
    for (int n = 0; n < LONG_RUN; n++) begin
      add_tick(n == 0, pick_step());
    end
    settle();
    calm = 1'b0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(pick_length(), pick_length(), pick_length(), pick_length(),
                     pick_level(), pick_level(), pick_level());
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      add_notes(PHASE_TICKS);
      if (p == 0) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        @(negedge clk);
      end
      settle();
    end

    $display("Checked %0d samples against %0d requests over %0d register settings,",
             checked_cnt, accepted_cnt, settings_cnt);
    $display("including zero-length segments, full-scale levels and notes past release.");
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Timeout with %0d samples still outstanding", expected_samples.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
